FILE: hw/rtl/hsfd_pkg.sv
// Shared types, constants and helper functions for the humidity sensor frame decoder.
`default_nettype none

package hsfd_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [16:0] FULL_SCALE  = 17'd65535;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TEMP_BAD = 2'd1,
      STATUS_HUM_BAD  = 2'd2
   } status_type;

   // one decoded frame handed from the front end to the conversion back end
   typedef struct packed {
      logic [15:0] temp_word;
      logic [15:0] hum_word;
      status_type  status;
   } job_type;

   // one byte through the CRC-8, msb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // floor(x / 65535) for x below 2^31: 65535 = 2^16 - 1, so the remainder
   // after x >> 16 is low16 + q, which stays below twice the divisor
   function automatic logic [14:0] div_full_scale(input logic [30:0] x);
      logic [14:0] q;
      logic [16:0] r;
      q = x[30:16];
      r = {1'b0, x[15:0]} + {2'b00, q};
      return (r >= FULL_SCALE) ? q + 15'd1 : q;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hsfd_front.sv
// Front end: takes sensor bytes, runs the CRC and assembles one frame job.
`default_nettype none

module hsfd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire logic             frame_start,
   output logic                  push,
   output hsfd_pkg::job_type     push_job
);

   typedef enum logic [2:0] {
      POS_T_HI,
      POS_T_LO,
      POS_T_CRC,
      POS_H_HI,
      POS_H_LO,
      POS_H_CRC
   } pos_type;

   pos_type     pos_ff, pos_in, pos_cur;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] tw_ff, tw_in;
   logic [15:0] hw_ff, hw_in;
   logic        tbad_ff, tbad_in;
   logic        last_byte;

   // a start mark restarts the frame on this byte
   assign pos_cur = frame_start ? POS_T_HI : pos_ff;

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      tw_in     = tw_ff;
      hw_in     = hw_ff;
      tbad_in   = tbad_ff;
      last_byte = 1'b0;
      case (pos_cur)
         POS_T_HI: begin
            crc_in  = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, data_byte);
            tw_in   = {data_byte, 8'h00};
            tbad_in = 1'b0;
            pos_in  = POS_T_LO;
         end
         POS_T_LO: begin
            crc_in = hsfd_pkg::crc8_byte(crc_ff, data_byte);
            tw_in  = {tw_ff[15:8], data_byte};
            pos_in = POS_T_CRC;
         end
         POS_T_CRC: begin
            tbad_in = (crc_ff != data_byte);
            crc_in  = hsfd_pkg::CRC_INIT;
            pos_in  = POS_H_HI;
         end
         POS_H_HI: begin
            crc_in = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, data_byte);
            hw_in  = {data_byte, 8'h00};
            pos_in = POS_H_LO;
         end
         POS_H_LO: begin
            crc_in = hsfd_pkg::crc8_byte(crc_ff, data_byte);
            hw_in  = {hw_ff[15:8], data_byte};
            pos_in = POS_H_CRC;
         end
         POS_H_CRC: begin
            last_byte = 1'b1;
            crc_in    = hsfd_pkg::CRC_INIT;
            pos_in    = POS_T_HI;
         end
         default: begin
            pos_in = POS_T_HI;
            crc_in = hsfd_pkg::CRC_INIT;
         end
      endcase
   end

   // temperature failure takes precedence over humidity
   always_comb begin
      push_job.temp_word = tw_ff;
      push_job.hum_word  = hw_ff;
      if (tbad_ff) begin
         push_job.status = hsfd_pkg::STATUS_TEMP_BAD;
      end else if (crc_ff != data_byte) begin
         push_job.status = hsfd_pkg::STATUS_HUM_BAD;
      end else begin
         push_job.status = hsfd_pkg::STATUS_OK;
      end
   end

   assign push = accept && last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_T_HI;
         crc_ff  <= hsfd_pkg::CRC_INIT;
         tw_ff   <= '0;
         hw_ff   <= '0;
         tbad_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         tw_ff   <= tw_in;
         hw_ff   <= hw_in;
         tbad_ff <= tbad_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/hsfd_queue.sv
// Short job queue between the front end and the conversion back end.
`default_nettype none

module hsfd_queue #(
   parameter int DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire hsfd_pkg::job_type push_job,
   output logic                   full,
   output logic                   job_valid,
   output hsfd_pkg::job_type      job,
   input  wire logic              pop
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

   hsfd_pkg::job_type entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_pop;

   assign full      = (count_ff == DepthCnt);
   assign job_valid = (count_ff != '0);
   assign job       = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && job_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/hsfd_back.sv
// Back end: scales raw words to centi-units in two stages, ending in the output register.
`default_nettype none

module hsfd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire hsfd_pkg::job_type job,
   output logic                   pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [14:0]            temperature_centi,
   output logic [13:0]            humidity_centi,
   output logic [1:0]             status
);

   logic                 s1_valid_ff;
   logic [30:0]          s1_tprod_ff, s1_tprod_in;
   logic [30:0]          s1_hprod_ff, s1_hprod_in;
   hsfd_pkg::status_type s1_status_ff;

   logic                 s2_valid_ff;
   logic [14:0]          s2_temp_ff, s2_temp_in;
   logic [13:0]          s2_hum_ff, s2_hum_in;
   hsfd_pkg::status_type s2_status_ff;

   logic        adv1, adv2;
   logic [14:0] t_quot, h_quot;
   logic [15:0] t_centi;

   assign adv2 = !s2_valid_ff || out_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign pop  = job_valid && adv1;

   assign s1_tprod_in = 31'(job.temp_word) * 31'(hsfd_pkg::TEMP_SCALE);
   assign s1_hprod_in = 31'(job.hum_word) * 31'(hsfd_pkg::HUM_SCALE);

   assign t_quot  = hsfd_pkg::div_full_scale(s1_tprod_ff);
   assign h_quot  = hsfd_pkg::div_full_scale(s1_hprod_ff);
   assign t_centi = {1'b0, t_quot} - hsfd_pkg::TEMP_OFFSET;

   // values read as zero whenever either check failed
   always_comb begin
      if (s1_status_ff == hsfd_pkg::STATUS_OK) begin
         s2_temp_in = t_centi[14:0];
         s2_hum_in  = h_quot[13:0];
      end else begin
         s2_temp_in = '0;
         s2_hum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= job_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_tprod_ff  <= s1_tprod_in;
         s1_hprod_ff  <= s1_hprod_in;
         s1_status_ff <= job.status;
      end
      if (s1_valid_ff && adv2) begin
         s2_temp_ff   <= s2_temp_in;
         s2_hum_ff    <= s2_hum_in;
         s2_status_ff <= s1_status_ff;
      end
   end

   assign out_valid         = s2_valid_ff;
   assign temperature_centi = s2_temp_ff;
   assign humidity_centi    = s2_hum_ff;
   assign status            = s2_status_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/humidity_sensor_frame_decoder.sv
// Top level of the humidity sensor frame decoder.
//
//   channel | dir | tdata                                       | tuser
//   req_    | in  | [7:0] data_byte                             | frame_start
//   rsp_    | out | [14:0] temperature_centi, [28:15] humidity_centi, [30:29] status | -
//
// One byte is accepted per cycle while req_tready is high; a frame of six bytes gives one item.
// After the sixth byte the job is registered in the queue, the multiply
// stage and the scale/output stage, advancing when the output is not stalled.
// Reset is synchronous; no clearing pass follows.
// req_tready drops only while the job queue is full, which needs the
// output to stall for several frames.
`default_nettype none

module humidity_sensor_frame_decoder #(
   parameter int QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [14:0] temperature_centi, [28:15] humidity_centi,
                                         // [30:29] status, [31] zero
);

   logic              accept;
   logic              push;
   hsfd_pkg::job_type push_job;
   logic              q_full;
   logic              job_valid;
   hsfd_pkg::job_type job;
   logic              pop;
   logic [14:0]       temperature_centi;
   logic [13:0]       humidity_centi;
   logic [1:0]        status;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   hsfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .frame_start (req_tuser),
      .push        (push),
      .push_job    (push_job)
   );

   hsfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .job_valid (job_valid),
      .job       (job),
      .pop       (pop)
   );

   hsfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (job_valid),
      .job               (job),
      .pop               (pop),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .temperature_centi (temperature_centi),
      .humidity_centi    (humidity_centi),
      .status            (status)
   );

   assign rsp_tdata = {1'b0, status, humidity_centi, temperature_centi};

endmodule

`default_nettype wire

FILE: hw/rtl/hsfd_checker.sv
// Port-level checks for the humidity sensor frame decoder, bound to the top level.
`default_nettype none

module hsfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // failed frames carry zero values
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[30:29] != hsfd_pkg::STATUS_OK |-> rsp_tdata[28:0] == 29'd0)
      else $error("non-zero values on a failed frame");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[28:15] <= 14'd10000
                     && $signed(rsp_tdata[14:0]) >= -15'sd4500
                     && $signed(rsp_tdata[14:0]) <= 15'sd13000
                     && rsp_tdata[31] == 1'b0)
      else $error("result value out of range");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (.*);

`default_nettype wire
